[hw/rtl/rtsf_pkg.sv]
// Shared types, constants and a helper function for the RC throttle/steer failsafe block.
package rtsf_pkg;

  // Timer width default
  localparam int unsigned TIMER_BITS_DEF = 16;

  // Register field widths
  localparam int unsigned PULSE_W = 12;
  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned MS_W    = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // Product width for the gas mapping
  localparam int unsigned GAS_PROD_W   = LEVEL_W + PULSE_W;

  // Brake ramp step and output reset values
  localparam logic [PULSE_W-1:0] BRAKE_STEP     = 12'd25;
  localparam logic [PULSE_W-1:0] BRAKE_RST      = 12'd1450;
  localparam logic [PULSE_W-1:0] THROTTLE_RST   = 12'd1500;
  localparam logic [LEVEL_W-1:0] STEER_RST      = 8'd60;

  // Configuration register reset values
  localparam logic [LEVEL_W-1:0] DEADZONE_RST   = 8'd39;
  localparam logic [PULSE_W-1:0] GAS_MIN_RST    = 12'd1500;
  localparam logic [PULSE_W-1:0] GAS_MAX_RST    = 12'd1600;
  localparam logic [PULSE_W-1:0] BRAKE_LIM_RST  = 12'd1200;
  localparam logic [PULSE_W-1:0] BRAKE_REL_RST  = 12'd1450;
  localparam logic [LEVEL_W-1:0] STEER_MAX_RST  = 8'd120;
  localparam logic [MS_W-1:0]    HOLDOFF_RST    = 16'd50;
  localparam logic [MS_W-1:0]    TIMEOUT_RST    = 16'd250;

  // Mode flag value that requests braking
  localparam logic [1:0] MODE_BRAKE = 2'd2;

  // Item kinds
  typedef enum logic {
    CMD_PACKET = 1'b0,
    CMD_POLL   = 1'b1
  } cmd_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE  = 3'd0,
    REG_GAS_MIN   = 3'd1,
    REG_GAS_MAX   = 3'd2,
    REG_BRAKE_LIM = 3'd3,
    REG_BRAKE_REL = 3'd4,
    REG_STEER_MAX = 3'd5,
    REG_HOLDOFF   = 3'd6,
    REG_TIMEOUT   = 3'd7
  } cfg_idx_t;

  // Where the throttle pulse comes from for one item
  typedef enum logic [1:0] {
    THR_KEEP  = 2'd0,
    THR_BRAKE = 2'd1,
    THR_GAS   = 2'd2
  } thr_src_t;

  // Floor division by 255 for x < 2^20: multiply by ceil(2^28/255) = 0x101011
  // as a sum of shifted copies, keep the bits above 2^28.
  function automatic logic [12:0] div255(input logic [GAS_PROD_W-1:0] x);
    logic [40:0] xw;
    logic [40:0] acc;
    xw  = {21'd0, x};
    acc = (xw << 20) + (xw << 12) + (xw << 4) + xw;
    return acc[40:28];
  endfunction

endpackage

[hw/rtl/rc_throttle_steer_failsafe_core.sv]
// Top level: RC throttle/brake/steering command processor with signal-loss failsafe.
// An item passes through the product stage and then the result register.
// Throughput: one item per cycle; in_stall rises only when both the product
//   stage and the result register are full and out_stall is high.
// Reset (rst_n low, synchronous) restores the configuration, state and result registers
//   to their defaults and empties the pipeline.
module rc_throttle_steer_failsafe_core #(
  parameter int unsigned TIMER_BITS = rtsf_pkg::TIMER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write port
  input  logic                              cfg_we,
  input  logic [rtsf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtsf_pkg::CFG_W-1:0]        cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [7:0]                        in_elapsed_ms,
  input  logic [7:0]                        in_gas_level,
  input  logic [7:0]                        in_steer_level,
  input  logic [1:0]                        in_mode_flag,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [11:0]                       out_throttle_us,
  output logic                              out_throttle_update,
  output logic [7:0]                        out_steer_angle,
  output logic                              out_steer_update,
  output logic                              out_failsafe_active
);

  localparam int unsigned TW1   = TIMER_BITS + 1;
  localparam int unsigned CMP_W = (TIMER_BITS > rtsf_pkg::MS_W) ? TIMER_BITS : rtsf_pkg::MS_W;

  // Configuration registers
  logic [7:0]  cfg_deadzone_r;
  logic [11:0] cfg_gas_min_r;
  logic [11:0] cfg_gas_max_r;
  logic [11:0] cfg_brake_lim_r;
  logic [11:0] cfg_brake_rel_r;
  logic [7:0]  cfg_steer_max_r;
  logic [15:0] cfg_holdoff_r;
  logic [15:0] cfg_timeout_r;

  // Control state
  logic [11:0]           brake_pulse_r, brake_pulse_nxt;
  logic [7:0]            last_gas_r, last_gas_nxt;
  logic [7:0]            last_steer_r, last_steer_nxt;
  logic [TIMER_BITS-1:0] since_pkt_r, since_pkt_nxt;
  logic [TIMER_BITS-1:0] since_steer_r, since_steer_nxt;

  // Product stage
  logic                   s1_valid_r;
  rtsf_pkg::thr_src_t     s1_thr_src_r, s1_thr_src_nxt;
  logic [11:0]            s1_brake_r;
  logic [19:0]            s1_gas_prod_r, s1_gas_prod_nxt;
  logic                   s1_gas_neg_r, s1_gas_neg_nxt;
  logic [11:0]            s1_gas_min_r;
  logic                   s1_steer_upd_r, s1_steer_upd_nxt;
  logic [15:0]            s1_steer_prod_r, s1_steer_prod_nxt;
  logic                   s1_fs_r, s1_fs_nxt;

  // Result register
  logic        out_valid_r;
  logic [11:0] throttle_hold_r;
  logic [7:0]  steer_hold_r;
  logic        out_thr_upd_r;
  logic        out_steer_upd_r;
  logic        out_fs_r;

  // Handshake
  logic in_xfer;
  logic out_xfer;
  logic out_load;

  // Stage-A combinational signals
  logic [TW1-1:0]        pkt_sum;
  logic [TW1-1:0]        steer_sum;
  logic [TIMER_BITS-1:0] pkt_sat;
  logic [TIMER_BITS-1:0] steer_sat;
  logic [11:0]           brake_dn;
  logic [7:0]            gas_eff;
  logic [11:0]           gas_mag;
  logic                  steer_ok;
  logic                  timeout_hit;

  // Stage-B combinational signals
  logic [12:0] gas_quo;
  logic [12:0] steer_quo;
  logic [11:0] thr_gas;

  // Pipeline flow control
  assign out_xfer = out_valid_r && !out_stall;
  assign out_load = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !out_load;
  assign in_xfer  = in_valid && !in_stall;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_deadzone_r  <= rtsf_pkg::DEADZONE_RST;
      cfg_gas_min_r   <= rtsf_pkg::GAS_MIN_RST;
      cfg_gas_max_r   <= rtsf_pkg::GAS_MAX_RST;
      cfg_brake_lim_r <= rtsf_pkg::BRAKE_LIM_RST;
      cfg_brake_rel_r <= rtsf_pkg::BRAKE_REL_RST;
      cfg_steer_max_r <= rtsf_pkg::STEER_MAX_RST;
      cfg_holdoff_r   <= rtsf_pkg::HOLDOFF_RST;
      cfg_timeout_r   <= rtsf_pkg::TIMEOUT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rtsf_pkg::REG_DEADZONE:  cfg_deadzone_r  <= cfg_wdata[7:0];
        rtsf_pkg::REG_GAS_MIN:   cfg_gas_min_r   <= cfg_wdata[11:0];
        rtsf_pkg::REG_GAS_MAX:   cfg_gas_max_r   <= cfg_wdata[11:0];
        rtsf_pkg::REG_BRAKE_LIM: cfg_brake_lim_r <= cfg_wdata[11:0];
        rtsf_pkg::REG_BRAKE_REL: cfg_brake_rel_r <= cfg_wdata[11:0];
        rtsf_pkg::REG_STEER_MAX: cfg_steer_max_r <= cfg_wdata[7:0];
        rtsf_pkg::REG_HOLDOFF:   cfg_holdoff_r   <= cfg_wdata;
        rtsf_pkg::REG_TIMEOUT:   cfg_timeout_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturating time counters
  assign pkt_sum   = {1'b0, since_pkt_r} + TW1'(in_elapsed_ms);
  assign steer_sum = {1'b0, since_steer_r} + TW1'(in_elapsed_ms);
  assign pkt_sat   = pkt_sum[TIMER_BITS] ? '1 : pkt_sum[TIMER_BITS-1:0];
  assign steer_sat = steer_sum[TIMER_BITS] ? '1 : steer_sum[TIMER_BITS-1:0];

  // Brake ramp step, floored at zero
  always_comb begin
    brake_dn = brake_pulse_r;
    if (brake_pulse_r > cfg_brake_lim_r) begin
      brake_dn = (brake_pulse_r >= rtsf_pkg::BRAKE_STEP) ?
                 brake_pulse_r - rtsf_pkg::BRAKE_STEP : '0;
    end
  end

  // Gas deadzone and span magnitude (inverted range maps downward)
  assign gas_eff  = (in_gas_level < cfg_deadzone_r) ? 8'd0 : in_gas_level;
  assign s1_gas_neg_nxt = cfg_gas_max_r < cfg_gas_min_r;
  assign gas_mag  = s1_gas_neg_nxt ? cfg_gas_min_r - cfg_gas_max_r
                                   : cfg_gas_max_r - cfg_gas_min_r;

  assign steer_ok    = (in_steer_level != last_steer_r) &&
                       (CMP_W'(steer_sat) >= CMP_W'(cfg_holdoff_r));
  assign timeout_hit = CMP_W'(pkt_sat) > CMP_W'(cfg_timeout_r);

  assign s1_gas_prod_nxt   = 20'(gas_eff) * 20'(gas_mag);
  assign s1_steer_prod_nxt = 16'(in_steer_level) * 16'(cfg_steer_max_r);

  // Per-item decisions and state update
  always_comb begin
    brake_pulse_nxt  = brake_pulse_r;
    last_gas_nxt     = last_gas_r;
    last_steer_nxt   = last_steer_r;
    since_pkt_nxt    = pkt_sat;
    since_steer_nxt  = steer_sat;
    s1_thr_src_nxt   = rtsf_pkg::THR_KEEP;
    s1_steer_upd_nxt = 1'b0;
    s1_fs_nxt        = 1'b0;
    if (in_cmd == rtsf_pkg::CMD_PACKET) begin
      if (in_mode_flag == rtsf_pkg::MODE_BRAKE) begin
        brake_pulse_nxt = brake_dn;
        s1_thr_src_nxt  = rtsf_pkg::THR_BRAKE;
      end else begin
        brake_pulse_nxt = cfg_brake_rel_r;
        if (in_gas_level != last_gas_r) begin
          last_gas_nxt   = gas_eff;
          s1_thr_src_nxt = rtsf_pkg::THR_GAS;
        end
      end
      if (steer_ok) begin
        last_steer_nxt   = in_steer_level;
        since_steer_nxt  = '0;
        s1_steer_upd_nxt = 1'b1;
      end
      since_pkt_nxt = '0;
    end else if (timeout_hit) begin
      brake_pulse_nxt = brake_dn;
      s1_thr_src_nxt  = rtsf_pkg::THR_BRAKE;
      s1_fs_nxt       = 1'b1;
    end
  end

  // State registers, committed on each input transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      brake_pulse_r <= rtsf_pkg::BRAKE_RST;
      last_gas_r    <= '0;
      last_steer_r  <= '0;
      since_pkt_r   <= '0;
      since_steer_r <= '0;
    end else if (in_xfer) begin
      brake_pulse_r <= brake_pulse_nxt;
      last_gas_r    <= last_gas_nxt;
      last_steer_r  <= last_steer_nxt;
      since_pkt_r   <= since_pkt_nxt;
      since_steer_r <= since_steer_nxt;
    end
  end

  // Product stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (out_load) begin
      s1_valid_r <= 1'b0;
    end
  end

  // Product stage payload
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_thr_src_r    <= s1_thr_src_nxt;
      s1_brake_r      <= brake_pulse_nxt;
      s1_gas_prod_r   <= s1_gas_prod_nxt;
      s1_gas_neg_r    <= s1_gas_neg_nxt;
      s1_gas_min_r    <= cfg_gas_min_r;
      s1_steer_upd_r  <= s1_steer_upd_nxt;
      s1_steer_prod_r <= s1_steer_prod_nxt;
      s1_fs_r         <= s1_fs_nxt;
    end
  end

  // Divide by full scale and offset from the gas minimum
  assign gas_quo   = rtsf_pkg::div255(s1_gas_prod_r);
  assign steer_quo = rtsf_pkg::div255(20'(s1_steer_prod_r));
  assign thr_gas   = s1_gas_neg_r ? s1_gas_min_r - gas_quo[11:0]
                                  : s1_gas_min_r + gas_quo[11:0];

  // Result register; the held pulse and angle are the outputs themselves
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r     <= 1'b0;
      throttle_hold_r <= rtsf_pkg::THROTTLE_RST;
      steer_hold_r    <= rtsf_pkg::STEER_RST;
      out_thr_upd_r   <= 1'b0;
      out_steer_upd_r <= 1'b0;
      out_fs_r        <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
      case (s1_thr_src_r)
        rtsf_pkg::THR_BRAKE: throttle_hold_r <= s1_brake_r;
        rtsf_pkg::THR_GAS:   throttle_hold_r <= thr_gas;
        default: ;
      endcase
      if (s1_steer_upd_r) begin
        steer_hold_r <= steer_quo[7:0];
      end
      out_thr_upd_r   <= (s1_thr_src_r != rtsf_pkg::THR_KEEP);
      out_steer_upd_r <= s1_steer_upd_r;
      out_fs_r        <= s1_fs_r;
    end else if (out_xfer) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_throttle_us     = throttle_hold_r;
  assign out_throttle_update = out_thr_upd_r;
  assign out_steer_angle     = steer_hold_r;
  assign out_steer_update    = out_steer_upd_r;
  assign out_failsafe_active = out_fs_r;

endmodule

[hw/rtl/rtsf_checker.sv]
// Port-level checker for the RC throttle/steer failsafe block, with its bind.
module rtsf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] out_throttle_us,
  input logic        out_throttle_update,
  input logic [7:0]  out_steer_angle,
  input logic        out_steer_update,
  input logic        out_failsafe_active
);

  // Reset empties the result register
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // With no pending result the block must take input
  a_no_stall_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while result register empty");

  // Failsafe braking always sets the throttle
  a_fs_thr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_failsafe_active |-> out_throttle_update)
    else $error("failsafe without throttle update");

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_throttle_us) &&
    $stable(out_steer_angle) && $stable(out_throttle_update) &&
    $stable(out_steer_update) && $stable(out_failsafe_active))
    else $error("stalled result changed");

endmodule

bind rc_throttle_steer_failsafe_core rtsf_checker u_rtsf_checker (.*);

[verif/tb_rc_throttle_steer_failsafe_core.sv]
// Testbench for rc_throttle_steer_failsafe_core: scripted and random items checked by a predictor.
module tb_rc_throttle_steer_failsafe_core;

  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;
  localparam int SILENCE_LEN  = 260;
  localparam int HOLDOFF_CYC  = 150;
  localparam int RUN_LIMIT    = 800000;

  // One result transfer, field by field
  typedef struct packed {
    logic [11:0] throttle_us;
    logic        throttle_update;
    logic [7:0]  steer_angle;
    logic        steer_update;
    logic        failsafe_active;
  } drive_out_t;

  // One scripted step: a register write or an item
  typedef struct {
    bit                  is_write;
    rtsf_pkg::cfg_idx_t  reg_sel;
    logic [15:0]         reg_val;
    rtsf_pkg::cmd_t      cmd;
    logic [7:0]          elapsed;
    logic [7:0]          gas;
    logic [7:0]          steer;
    logic [1:0]          mode;
    bit                  typed;
    drive_out_t          want;
  } script_row_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  rtsf_pkg::cfg_idx_t          cfg_index = rtsf_pkg::REG_DEADZONE;
  logic [rtsf_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic                        in_cmd = 1'b0;
  logic [7:0]                  in_elapsed_ms = '0;
  logic [7:0]                  in_gas_level = '0;
  logic [7:0]                  in_steer_level = '0;
  logic [1:0]                  in_mode_flag = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [11:0]                 out_throttle_us;
  logic                        out_throttle_update;
  logic [7:0]                  out_steer_angle;
  logic                        out_steer_update;
  logic                        out_failsafe_active;

  // Register copies for prediction
  logic [7:0]  reg_deadzone  = rtsf_pkg::DEADZONE_RST;
  logic [11:0] reg_gas_min   = rtsf_pkg::GAS_MIN_RST;
  logic [11:0] reg_gas_max   = rtsf_pkg::GAS_MAX_RST;
  logic [11:0] reg_brake_lim = rtsf_pkg::BRAKE_LIM_RST;
  logic [11:0] reg_brake_rel = rtsf_pkg::BRAKE_REL_RST;
  logic [7:0]  reg_steer_max = rtsf_pkg::STEER_MAX_RST;
  logic [15:0] reg_holdoff   = rtsf_pkg::HOLDOFF_RST;
  logic [15:0] reg_timeout   = rtsf_pkg::TIMEOUT_RST;

  // Predicted block state
  logic [11:0] sim_brake_us    = rtsf_pkg::BRAKE_RST;
  logic [7:0]  sim_last_gas    = '0;
  logic [7:0]  sim_last_steer  = '0;
  logic [15:0] sim_since_pkt   = '0;
  logic [15:0] sim_since_steer = '0;
  logic [11:0] sim_throttle_us = rtsf_pkg::THROTTLE_RST;
  logic [7:0]  sim_steer_deg   = rtsf_pkg::STEER_RST;

  drive_out_t  due_outputs[$];
  script_row_t script[$];

  int  fail_count = 0;
  int  item_count = 0;
  int  n_packets = 0;
  int  n_polls = 0;
  int  n_failsafe = 0;
  int  n_steer_moves = 0;
  int  n_settings = 0;
  bit  no_idle = 1'b0;
  bit  want_holdoff = 1'b0;
  int  hold_left = 0;
  bit  holdoff_done = 1'b0;

  rc_throttle_steer_failsafe_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_cmd              (in_cmd),
    .in_elapsed_ms       (in_elapsed_ms),
    .in_gas_level        (in_gas_level),
    .in_steer_level      (in_steer_level),
    .in_mode_flag        (in_mode_flag),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_throttle_us     (out_throttle_us),
    .out_throttle_update (out_throttle_update),
    .out_steer_angle     (out_steer_angle),
    .out_steer_update    (out_steer_update),
    .out_failsafe_active (out_failsafe_active)
  );

  // Clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Saturating millisecond counter
  function automatic logic [15:0] ms_add(input logic [15:0] t, input logic [7:0] d);
    logic [16:0] sum;
    sum = {1'b0, t} + 17'(d);
    return sum[16] ? 16'hFFFF : sum[15:0];
  endfunction

  // Brake ramp: step down toward the limit, never below zero
  function automatic void brake_ramp();
    if (sim_brake_us > reg_brake_lim)
      sim_brake_us = (sim_brake_us >= rtsf_pkg::BRAKE_STEP) ?
                     sim_brake_us - rtsf_pkg::BRAKE_STEP : '0;
    sim_throttle_us = sim_brake_us;
  endfunction

  // Predicted outputs for one item; advances the predicted state
  function automatic drive_out_t predict_outputs(input rtsf_pkg::cmd_t c,
                                                 input logic [7:0] el,
                                                 input logic [7:0] gas_in,
                                                 input logic [7:0] steer,
                                                 input logic [1:0] mode);
    drive_out_t r;
    logic [7:0] gas;
    int span, q, pulse;
    r = '0;
    gas = gas_in;
    sim_since_pkt = ms_add(sim_since_pkt, el);
    sim_since_steer = ms_add(sim_since_steer, el);
    if (c == rtsf_pkg::CMD_PACKET) begin
      n_packets++;
      if (mode == rtsf_pkg::MODE_BRAKE) begin
        brake_ramp();
        r.throttle_update = 1'b1;
      end else begin
        sim_brake_us = reg_brake_rel;
        if (gas != sim_last_gas) begin
          if (gas < reg_deadzone) gas = '0;
          // signed span, division truncates toward zero
          span = int'(reg_gas_max) - int'(reg_gas_min);
          q = (int'(gas) * span) / 255;
          pulse = int'(reg_gas_min) + q;
          sim_throttle_us = pulse[11:0];
          sim_last_gas = gas;
          r.throttle_update = 1'b1;
        end
      end
      if (steer != sim_last_steer && sim_since_steer >= reg_holdoff) begin
        q = (int'(steer) * int'(reg_steer_max)) / 255;
        sim_steer_deg = q[7:0];
        sim_last_steer = steer;
        sim_since_steer = '0;
        r.steer_update = 1'b1;
        n_steer_moves++;
      end
      sim_since_pkt = '0;
    end else begin
      n_polls++;
      if (sim_since_pkt > reg_timeout) begin
        brake_ramp();
        r.throttle_update = 1'b1;
        r.failsafe_active = 1'b1;
        n_failsafe++;
      end
    end
    r.throttle_us = sim_throttle_us;
    r.steer_angle = sim_steer_deg;
    return r;
  endfunction

  // Compare one result transfer with the oldest expectation
  task automatic check_outputs();
    drive_out_t want;
    if (due_outputs.size() == 0) begin
      $error("result transfer with nothing expected: throttle_us %0d steer_angle %0d",
             out_throttle_us, out_steer_angle);
      fail_count++;
    end else begin
      want = due_outputs.pop_front();
      if (out_throttle_us !== want.throttle_us) begin
        $error("throttle_us: expected %0d, got %0d", want.throttle_us, out_throttle_us);
        fail_count++;
      end
      if (out_throttle_update !== want.throttle_update) begin
        $error("throttle_update: expected %0d, got %0d", want.throttle_update,
               out_throttle_update);
        fail_count++;
      end
      if (out_steer_angle !== want.steer_angle) begin
        $error("steer_angle: expected %0d, got %0d", want.steer_angle, out_steer_angle);
        fail_count++;
      end
      if (out_steer_update !== want.steer_update) begin
        $error("steer_update: expected %0d, got %0d", want.steer_update, out_steer_update);
        fail_count++;
      end
      if (out_failsafe_active !== want.failsafe_active) begin
        $error("failsafe_active: expected %0d, got %0d", want.failsafe_active,
               out_failsafe_active);
        fail_count++;
      end
    end
  endtask

  // Result side: check transfers, drive stall (random, or one long hold-off)
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_outputs();
    if (want_holdoff && !holdoff_done) begin
      hold_left = HOLDOFF_CYC;
      holdoff_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !no_idle && ($urandom_range(0, 99) < 17);
    end
  end

  // Offer one item, wait for its transfer, record the expected result
  task automatic send_item(input rtsf_pkg::cmd_t c, input logic [7:0] el,
                           input logic [7:0] gas, input logic [7:0] steer,
                           input logic [1:0] mode,
                           input bit typed = 1'b0, input drive_out_t want = '0);
    drive_out_t model_out;
    if (!no_idle && $urandom_range(0, 99) < 17) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_cmd         <= c;
    in_elapsed_ms  <= el;
    in_gas_level   <= gas;
    in_steer_level <= steer;
    in_mode_flag   <= mode;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_out = predict_outputs(c, el, gas, steer, mode);
    due_outputs.push_back(typed ? want : model_out);
    item_count++;
  endtask

  // Register write once the block has drained; bits above the register width are junk
  task automatic write_reg(input rtsf_pkg::cfg_idx_t idx, input logic [15:0] val);
    logic [15:0] junk, data;
    junk = 16'($urandom);
    case (idx)
      rtsf_pkg::REG_DEADZONE, rtsf_pkg::REG_STEER_MAX: data = {junk[15:8], val[7:0]};
      rtsf_pkg::REG_HOLDOFF, rtsf_pkg::REG_TIMEOUT:    data = val;
      default:                                         data = {junk[15:12], val[11:0]};
    endcase
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rtsf_pkg::REG_DEADZONE:  reg_deadzone  = data[7:0];
      rtsf_pkg::REG_GAS_MIN:   reg_gas_min   = data[11:0];
      rtsf_pkg::REG_GAS_MAX:   reg_gas_max   = data[11:0];
      rtsf_pkg::REG_BRAKE_LIM: reg_brake_lim = data[11:0];
      rtsf_pkg::REG_BRAKE_REL: reg_brake_rel = data[11:0];
      rtsf_pkg::REG_STEER_MAX: reg_steer_max = data[7:0];
      rtsf_pkg::REG_HOLDOFF:   reg_holdoff   = data;
      rtsf_pkg::REG_TIMEOUT:   reg_timeout   = data;
      default: ;
    endcase
  endtask

  function automatic drive_out_t outs(input int thr, input bit tu, input int ang,
                                      input bit su, input bit fs);
    drive_out_t r;
    r.throttle_us     = 12'(thr);
    r.throttle_update = tu;
    r.steer_angle     = 8'(ang);
    r.steer_update    = su;
    r.failsafe_active = fs;
    return r;
  endfunction

  function automatic void add_item(input rtsf_pkg::cmd_t c, input int el, input int gas,
                                   input int steer, input int mode, input bit typed = 1'b0,
                                   input drive_out_t want = '0);
    script_row_t row;
    row.is_write = 1'b0;
    row.reg_sel  = rtsf_pkg::REG_DEADZONE;
    row.reg_val  = '0;
    row.cmd      = c;
    row.elapsed  = 8'(el);
    row.gas      = 8'(gas);
    row.steer    = 8'(steer);
    row.mode     = 2'(mode);
    row.typed    = typed;
    row.want     = want;
    script.push_back(row);
  endfunction

  function automatic void add_write(input rtsf_pkg::cfg_idx_t idx, input int val);
    script_row_t row;
    row.is_write = 1'b1;
    row.reg_sel  = idx;
    row.reg_val  = 16'(val);
    row.cmd      = rtsf_pkg::CMD_PACKET;
    row.elapsed  = '0;
    row.gas      = '0;
    row.steer    = '0;
    row.mode     = '0;
    row.typed    = 1'b0;
    row.want     = '0;
    script.push_back(row);
  endfunction

  // Directed script, starting from reset values
  function automatic void build_script();
    // nothing moves right after reset
    add_item(rtsf_pkg::CMD_POLL,     0,   0,   0, 0, 1, outs(1500, 0,  60, 0, 0));
    add_item(rtsf_pkg::CMD_PACKET,   0,   0,   0, 0, 1, outs(1500, 0,  60, 0, 0));
    // full gas and full steer
    add_item(rtsf_pkg::CMD_PACKET, 255, 255, 255, 0, 1, outs(1600, 1, 120, 1, 0));
    // below deadzone counts as zero, also when repeated; steer hold-off not yet met
    add_item(rtsf_pkg::CMD_PACKET,  10,  38, 255, 0, 1, outs(1500, 1, 120, 0, 0));
    add_item(rtsf_pkg::CMD_PACKET,  10,  38,   0, 0, 1, outs(1500, 1, 120, 0, 0));
    // at deadzone; hold-off met exactly
    add_item(rtsf_pkg::CMD_PACKET,  30,  39,   0, 0, 1, outs(1515, 1,   0, 1, 0));
    // brake packets ramp down from release
    add_item(rtsf_pkg::CMD_PACKET,   1,   0,   0, 2, 1, outs(1425, 1,   0, 0, 0));
    add_item(rtsf_pkg::CMD_PACKET,   0,   0,   0, 2, 1, outs(1400, 1,   0, 0, 0));
    // unchanged gas keeps the pulse; other mode values are plain packets
    add_item(rtsf_pkg::CMD_PACKET,   0,  39,   0, 1, 1, outs(1400, 0,   0, 0, 0));
    add_item(rtsf_pkg::CMD_PACKET,   0, 200,   0, 3, 1, outs(1578, 1,   0, 0, 0));
    // timeout reached but not exceeded, then exceeded; poll ignores payload
    add_item(rtsf_pkg::CMD_POLL,   250,   0,   0, 0, 1, outs(1578, 0,   0, 0, 0));
    add_item(rtsf_pkg::CMD_POLL,     1,   0,   0, 0, 1, outs(1425, 1,   0, 0, 1));
    add_item(rtsf_pkg::CMD_POLL,   255, 255, 255, 2, 1, outs(1400, 1,   0, 0, 1));
    // brake ramp stops at zero
    add_write(rtsf_pkg::REG_BRAKE_REL, 30);
    add_write(rtsf_pkg::REG_BRAKE_LIM, 0);
    add_item(rtsf_pkg::CMD_PACKET,   0,   0,   0, 0, 1, outs(1500, 1,   0, 0, 0));
    add_item(rtsf_pkg::CMD_PACKET,   0,   0,   0, 2, 1, outs(   5, 1,   0, 0, 0));
    add_item(rtsf_pkg::CMD_PACKET,   0,   0,   0, 2, 1, outs(   0, 1,   0, 0, 0));
    add_item(rtsf_pkg::CMD_PACKET,   0,   0,   0, 2, 1, outs(   0, 1,   0, 0, 0));
    // inverted gas range, widest steer, no hold-off
    add_write(rtsf_pkg::REG_GAS_MIN, 2500);
    add_write(rtsf_pkg::REG_GAS_MAX, 0);
    add_write(rtsf_pkg::REG_STEER_MAX, 180);
    add_write(rtsf_pkg::REG_HOLDOFF, 0);
    add_item(rtsf_pkg::CMD_PACKET,   0, 128, 255, 0);
    add_item(rtsf_pkg::CMD_PACKET,   0, 255,   1, 0);
    add_item(rtsf_pkg::CMD_PACKET,   0, 254, 128, 0);
  endfunction

  // Write all registers for one phase: defaults, all zero, all max, then random
  task automatic apply_setting(input int phase);
    logic [15:0] v [8];
    case (phase)
      0: v = '{rtsf_pkg::DEADZONE_RST, rtsf_pkg::GAS_MIN_RST, rtsf_pkg::GAS_MAX_RST,
               rtsf_pkg::BRAKE_LIM_RST, rtsf_pkg::BRAKE_REL_RST, rtsf_pkg::STEER_MAX_RST,
               rtsf_pkg::HOLDOFF_RST, rtsf_pkg::TIMEOUT_RST};
      1: v = '{0, 0, 0, 0, 0, 0, 0, 0};
      2: v = '{255, 2500, 2500, 2500, 2500, 180, 16'hFFFF, 16'hFFFF};
      default: begin
        v[0] = 16'($urandom_range(0, 255));
        v[1] = 16'($urandom_range(0, 2500));
        v[2] = 16'($urandom_range(0, 2500));
        v[3] = 16'($urandom_range(0, 2500));
        v[4] = 16'($urandom_range(0, 2500));
        v[5] = 16'($urandom_range(0, 180));
        v[6] = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 300));
        v[7] = ($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 600));
      end
    endcase
    for (int i = 0; i < 8; i++) write_reg(rtsf_pkg::cfg_idx_t'(i), v[i]);
    n_settings++;
  endtask

  // Random phase: packet runs with repeats and brakes, and stretches of lost signal
  task automatic run_phase(input int phase);
    int stop_at, run_len;
    logic [7:0] el, gas, steer, prev_gas, prev_steer;
    logic [1:0] mode;
    prev_gas = '0;
    prev_steer = '0;
    apply_setting(phase);
    no_idle = (phase == 4);
    if (phase == 5) want_holdoff = 1'b1;
    // long silence drives both time counters into saturation
    if (phase == 2)
      repeat (SILENCE_LEN)
        send_item(rtsf_pkg::CMD_POLL, 8'd255, 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
    stop_at = item_count + PHASE_ITEMS;
    while (item_count < stop_at) begin
      run_len = $urandom_range(1, 12);
      if ($urandom_range(0, 99) < 70) begin
        repeat (run_len) begin
          el = ($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 40));
          gas = ($urandom_range(0, 3) == 0) ? prev_gas : 8'($urandom_range(0, 255));
          steer = ($urandom_range(0, 2) == 0) ? prev_steer : 8'($urandom_range(0, 255));
          mode = ($urandom_range(0, 9) < 3) ? rtsf_pkg::MODE_BRAKE
                                            : 2'($urandom_range(0, 3));
          send_item(rtsf_pkg::CMD_PACKET, el, gas, steer, mode);
          prev_gas = gas;
          prev_steer = steer;
        end
      end else begin
        repeat (run_len + 4)
          send_item(rtsf_pkg::CMD_POLL, 8'($urandom_range(0, 255)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                    2'($urandom_range(0, 3)));
      end
    end
    no_idle = 1'b0;
  endtask

  // Main sequence
  initial begin
    build_script();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (script[i]) begin
      if (script[i].is_write)
        write_reg(script[i].reg_sel, script[i].reg_val);
      else
        send_item(script[i].cmd, script[i].elapsed, script[i].gas, script[i].steer,
                  script[i].mode, script[i].typed, script[i].want);
    end
    for (int p = 0; p < PHASES; p++) run_phase(p);
    in_valid <= 1'b0;
    while (due_outputs.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d items: %0d packets, %0d polls, %0d failsafe brakes,",
             item_count, n_packets, n_polls, n_failsafe);
    $display("%0d steering moves, %0d register settings, %0d mismatches",
             n_steer_moves, n_settings, fail_count);
    if (fail_count == 0)
      $display("rc_throttle_steer_failsafe_core regression: pass");
    else
      $display("rc_throttle_steer_failsafe_core regression: fail");
    $finish;
  end

  // Watchdog
  initial begin
    #RUN_LIMIT;
    $display("rc_throttle_steer_failsafe_core regression: fail");
    $finish;
  end

endmodule
